/* hw/rtl/tnt_pkg.sv */
package tnt_pkg;

    // Field widths of one corner and one result.
    localparam int POS_W  = 32;
    localparam int UV_W   = 16;
    localparam int NRM_W  = 16;
    localparam int TAN_W  = 32;
    localparam int FRAC_W = 14;

    // Edge and UV delta magnitudes, one bit wider than the fields.
    localparam int EDGE_W = POS_W + 1;
    localparam int DUV_W  = UV_W + 1;

    // Edges are scaled below this power of two before the cross product.
    localparam int NRM_PRE = 30;

    // Serial multiplier operand and product widths.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;
    localparam int MCNT_W = $clog2(MUL_W);

    // Serial divider widths.
    localparam int DIVD_W = 65;
    localparam int DVS_W  = 34;
    localparam int QUO_W  = 32;
    localparam int DCNT_W = $clog2(DIVD_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EPRE,
        ST_MUL,
        ST_CNORM,
        ST_SQRT,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/tnt_serial_mul.sv */
module tnt_serial_mul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tnt_pkg::MUL_W-1:0]  a,
    input  logic [tnt_pkg::MUL_W-1:0]  b,
    output logic                       done,
    output logic [tnt_pkg::PROD_W-1:0] prod
);
    import tnt_pkg::*;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [MCNT_W-1:0]   cnt_reg, cnt_next;
    logic [MUL_W-1:0]    mcand_reg, mcand_next;
    logic [PROD_W-1:0]   p_reg, p_next;
    logic [MUL_W:0]      sum;

    // One multiplier bit per cycle: add into the high half, then shift right.
    always_comb
    begin
        sum        = {1'b0, p_reg[PROD_W-1:MUL_W]} + {1'b0, (p_reg[0] ? mcand_reg : '0)};
        run_next   = run_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        mcand_next = mcand_reg;
        p_next     = p_reg;
        if (start)
        begin
            run_next   = 1'b1;
            cnt_next   = '0;
            mcand_next = a;
            p_next     = {{MUL_W{1'b0}}, b};
        end
        else if (run_reg)
        begin
            p_next   = {sum, p_reg[MUL_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MCNT_W'(MUL_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg <= mcand_next;
        p_reg     <= p_next;
    end

    assign done = done_reg;
    assign prod = p_reg;

endmodule

/* hw/rtl/tnt_serial_div.sv */
module tnt_serial_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tnt_pkg::DIVD_W-1:0] dividend,
    input  logic [tnt_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [tnt_pkg::QUO_W-1:0]  quo,
    output logic                       ovf,
    output logic                       round_up
);
    import tnt_pkg::*;

    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [DCNT_W-1:0]   cnt_reg, cnt_next;
    logic [DIVD_W-1:0]   dvd_reg, dvd_next;
    logic [DVS_W-1:0]    dvs_reg, dvs_next;
    logic [DVS_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]    quo_reg, quo_next;
    logic                ovf_reg, ovf_next;
    logic [DVS_W:0]      rem2;
    logic [DVS_W:0]      rem_sub;
    logic                ge;

    // Restoring division, one quotient bit per cycle. A one that leaves the
    // top of the quotient register is kept as a sticky overflow.
    always_comb
    begin
        rem2      = {rem_reg, dvd_reg[DIVD_W-1]};
        ge        = rem2 >= {1'b0, dvs_reg};
        rem_sub   = rem2 - {1'b0, dvs_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            dvd_next = dividend;
            dvs_next = divisor;
            rem_next = '0;
            quo_next = '0;
            ovf_next = 1'b0;
        end
        else if (run_reg)
        begin
            rem_next = ge ? rem_sub[DVS_W-1:0] : rem2[DVS_W-1:0];
            quo_next = {quo_reg[QUO_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[QUO_W-1];
            dvd_next = {dvd_reg[DIVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign done     = done_reg;
    assign quo      = quo_reg;
    assign ovf      = ovf_reg;
    assign round_up = {rem_reg, 1'b0} >= {1'b0, dvs_reg};

endmodule

/* hw/rtl/triangle_normal_tangent.sv */
// Triangle face normal and UV tangent. Corners arrive one word each; the
// first two of a triangle are held, and the third starts the computation
// and yields one result word with the unit normal (Q1.14), the tangent
// (Q17.14, saturated) and two degenerate flags. After its third corner a
// triangle passes the edge prescale, the bit-serial multiplier with 17
// products (the last three, the squares, after the normal scaling loop),
// the square root and the bit-serial divider with six quotients;
// degenerate cases skip the squares, the root or some of the quotients.
// The input stalls while a triangle is in work; a finished result may
// wait at the output while the next corners are taken.
module triangle_normal_tangent (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x[31:0], pos_y[63:32], pos_z[95:64], tex_u[111:96], tex_v[127:112]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x[15:0], normal_y[31:16], normal_z[47:32],
    // tangent_x[79:48], tangent_y[111:80], tangent_z[143:112]
    output logic [143:0] m_tdata,
    // normal_degenerate[0], uv_degenerate[1]
    output logic [1:0]   m_tuser
);
    import tnt_pkg::*;

    localparam int CM_W     = 62;
    localparam int NM_W     = 51;
    localparam int DET_W    = 34;
    localparam int SP_W     = PROD_W + 2;
    localparam int L2_W     = 64;
    localparam int SQ_STEPS = 32;
    localparam int SK_W     = $clog2(SQ_STEPS);
    localparam int ROOT_W   = 32;
    localparam int OUT_W    = 3 * NRM_W + 3 * TAN_W;

    // Product jobs of the multiplier, in issue order.
    localparam logic [4:0] J_A1A5 = 5'd0;
    localparam logic [4:0] J_A2A4 = 5'd1;
    localparam logic [4:0] J_A2A3 = 5'd2;
    localparam logic [4:0] J_A0A5 = 5'd3;
    localparam logic [4:0] J_A0A4 = 5'd4;
    localparam logic [4:0] J_A1A3 = 5'd5;
    localparam logic [4:0] J_D0D3 = 5'd6;
    localparam logic [4:0] J_D2D1 = 5'd7;
    localparam logic [4:0] J_D3E0 = 5'd8;
    localparam logic [4:0] J_D1E3 = 5'd9;
    localparam logic [4:0] J_D3E1 = 5'd10;
    localparam logic [4:0] J_D1E4 = 5'd11;
    localparam logic [4:0] J_D3E2 = 5'd12;
    localparam logic [4:0] J_D1E5 = 5'd13;
    localparam logic [4:0] J_SQ0  = 5'd14;
    localparam logic [4:0] J_SQ1  = 5'd15;
    localparam logic [4:0] J_SQ2  = 5'd16;

    // Divider jobs: three normal components, then three tangent components.
    localparam logic [2:0] DJ_FIRST_NRM = 3'd0;
    localparam logic [2:0] DJ_LAST_NRM  = 3'd2;
    localparam logic [2:0] DJ_FIRST_TAN = 3'd3;
    localparam logic [2:0] DJ_LAST_TAN  = 3'd5;

    localparam logic [QUO_W:0] NRM_ONE = (QUO_W+1)'(1) << FRAC_W;
    localparam logic [QUO_W:0] POS_LIM = ((QUO_W+1)'(1) << (TAN_W - 1)) - 1'b1;
    localparam logic [QUO_W:0] NEG_LIM = (QUO_W+1)'(1) << (TAN_W - 1);

    state_t              state_reg, state_next;
    logic [1:0]          corner_reg, corner_next;
    logic                issued_reg, issued_next;
    logic [4:0]          job_reg, job_next;
    logic [2:0]          djob_reg, djob_next;
    logic                ndeg_reg, ndeg_next;
    logic                udeg_reg, udeg_next;
    logic                m_tvalid_reg, m_tvalid_next;

    logic signed [POS_W-1:0] p0_reg [3];
    logic signed [POS_W-1:0] p0_next [3];
    logic signed [POS_W-1:0] p1_reg [3];
    logic signed [POS_W-1:0] p1_next [3];
    logic signed [UV_W-1:0]  t0_reg [2];
    logic signed [UV_W-1:0]  t0_next [2];
    logic signed [UV_W-1:0]  t1_reg [2];
    logic signed [UV_W-1:0]  t1_next [2];
    logic [EDGE_W-1:0]       em_reg [6];
    logic [EDGE_W-1:0]       em_next [6];
    logic [EDGE_W-1:0]       am_reg [6];
    logic [EDGE_W-1:0]       am_next [6];
    logic [5:0]              es_reg, es_next;
    logic [DUV_W-1:0]        dm_reg [4];
    logic [DUV_W-1:0]        dm_next [4];
    logic [3:0]              ds_reg, ds_next;
    logic [SP_W-1:0]         tmp_reg, tmp_next;
    logic [CM_W-1:0]         cm_reg [3];
    logic [CM_W-1:0]         cm_next [3];
    logic [2:0]              cs_reg, cs_next;
    logic [NM_W-1:0]         nm_reg [3];
    logic [NM_W-1:0]         nm_next [3];
    logic [2:0]              ns_reg, ns_next;
    logic [DET_W-1:0]        detm_reg, detm_next;
    logic                    dets_reg, dets_next;
    logic [L2_W-1:0]         l2_reg, l2_next;
    logic [L2_W-1:0]         sx_reg, sx_next;
    logic [L2_W-1:0]         sr_reg, sr_next;
    logic [SK_W-1:0]         sk_reg, sk_next;
    logic [NRM_W-1:0]        n_reg [3];
    logic [NRM_W-1:0]        n_next [3];
    logic [TAN_W-1:0]        tg_reg [3];
    logic [TAN_W-1:0]        tg_next [3];
    logic [OUT_W-1:0]        m_tdata_reg, m_tdata_next;
    logic [1:0]              m_tuser_reg, m_tuser_next;

    logic signed [POS_W-1:0] in_p [3];
    logic signed [UV_W-1:0]  in_t [2];
    logic [EDGE_W-1:0]       e_new [6];
    logic [DUV_W-1:0]        d_new [4];

    logic [MUL_W-1:0]        op_a, op_b;
    logic                    op_s;
    logic                    mul_start, mul_done;
    logic [PROD_W-1:0]       mul_prod;
    logic [SP_W-1:0]         prod_ext, ps, diff, dmag;
    logic                    dneg;

    logic                    div_start, div_done, div_ovf, div_rnd;
    logic [DIVD_W-1:0]       div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic [QUO_W-1:0]        div_quo;
    logic [1:0]              didx;
    logic                    is_nrm;

    logic                    e_big, c_any, c_hi, c_lo;
    logic [L2_W-1:0]         sbit, stry;
    logic [QUO_W:0]          qr, nmag, tlim, tmag, tval;
    logic [NRM_W-1:0]        nmag_s;
    logic                    tneg;

    assign in_p[0] = s_tdata[POS_W-1:0];
    assign in_p[1] = s_tdata[2*POS_W-1:POS_W];
    assign in_p[2] = s_tdata[3*POS_W-1:2*POS_W];
    assign in_t[0] = s_tdata[3*POS_W+UV_W-1:3*POS_W];
    assign in_t[1] = s_tdata[3*POS_W+2*UV_W-1:3*POS_W+UV_W];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e_new[i]     = {p1_reg[i][POS_W-1], p1_reg[i]} - {p0_reg[i][POS_W-1], p0_reg[i]};
            e_new[i + 3] = {in_p[i][POS_W-1], in_p[i]} - {p0_reg[i][POS_W-1], p0_reg[i]};
        end
        d_new[0] = {t1_reg[0][UV_W-1], t1_reg[0]} - {t0_reg[0][UV_W-1], t0_reg[0]};
        d_new[1] = {t1_reg[1][UV_W-1], t1_reg[1]} - {t0_reg[1][UV_W-1], t0_reg[1]};
        d_new[2] = {in_t[0][UV_W-1], in_t[0]} - {t0_reg[0][UV_W-1], t0_reg[0]};
        d_new[3] = {in_t[1][UV_W-1], in_t[1]} - {t0_reg[1][UV_W-1], t0_reg[1]};
    end

    // Operand selection for the multiplier; magnitudes with a product sign.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        op_s = 1'b0;
        unique case (job_reg)
            J_A1A5:
            begin
                op_a = MUL_W'(am_reg[1]); op_b = MUL_W'(am_reg[5]); op_s = es_reg[1] ^ es_reg[5];
            end
            J_A2A4:
            begin
                op_a = MUL_W'(am_reg[2]); op_b = MUL_W'(am_reg[4]); op_s = es_reg[2] ^ es_reg[4];
            end
            J_A2A3:
            begin
                op_a = MUL_W'(am_reg[2]); op_b = MUL_W'(am_reg[3]); op_s = es_reg[2] ^ es_reg[3];
            end
            J_A0A5:
            begin
                op_a = MUL_W'(am_reg[0]); op_b = MUL_W'(am_reg[5]); op_s = es_reg[0] ^ es_reg[5];
            end
            J_A0A4:
            begin
                op_a = MUL_W'(am_reg[0]); op_b = MUL_W'(am_reg[4]); op_s = es_reg[0] ^ es_reg[4];
            end
            J_A1A3:
            begin
                op_a = MUL_W'(am_reg[1]); op_b = MUL_W'(am_reg[3]); op_s = es_reg[1] ^ es_reg[3];
            end
            J_D0D3:
            begin
                op_a = MUL_W'(dm_reg[0]); op_b = MUL_W'(dm_reg[3]); op_s = ds_reg[0] ^ ds_reg[3];
            end
            J_D2D1:
            begin
                op_a = MUL_W'(dm_reg[2]); op_b = MUL_W'(dm_reg[1]); op_s = ds_reg[2] ^ ds_reg[1];
            end
            J_D3E0:
            begin
                op_a = MUL_W'(dm_reg[3]); op_b = MUL_W'(em_reg[0]); op_s = ds_reg[3] ^ es_reg[0];
            end
            J_D1E3:
            begin
                op_a = MUL_W'(dm_reg[1]); op_b = MUL_W'(em_reg[3]); op_s = ds_reg[1] ^ es_reg[3];
            end
            J_D3E1:
            begin
                op_a = MUL_W'(dm_reg[3]); op_b = MUL_W'(em_reg[1]); op_s = ds_reg[3] ^ es_reg[1];
            end
            J_D1E4:
            begin
                op_a = MUL_W'(dm_reg[1]); op_b = MUL_W'(em_reg[4]); op_s = ds_reg[1] ^ es_reg[4];
            end
            J_D3E2:
            begin
                op_a = MUL_W'(dm_reg[3]); op_b = MUL_W'(em_reg[2]); op_s = ds_reg[3] ^ es_reg[2];
            end
            J_D1E5:
            begin
                op_a = MUL_W'(dm_reg[1]); op_b = MUL_W'(em_reg[5]); op_s = ds_reg[1] ^ es_reg[5];
            end
            J_SQ0:
            begin
                op_a = MUL_W'(cm_reg[0][30:0]); op_b = MUL_W'(cm_reg[0][30:0]);
            end
            J_SQ1:
            begin
                op_a = MUL_W'(cm_reg[1][30:0]); op_b = MUL_W'(cm_reg[1][30:0]);
            end
            J_SQ2:
            begin
                op_a = MUL_W'(cm_reg[2][30:0]); op_b = MUL_W'(cm_reg[2][30:0]);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
    end

    assign prod_ext = {2'b00, mul_prod};
    assign ps       = op_s ? (~prod_ext + 1'b1) : prod_ext;
    assign diff     = tmp_reg - ps;
    assign dneg     = diff[SP_W-1];
    assign dmag     = dneg ? (~diff + 1'b1) : diff;

    // Divider operands: normal components over the root, tangent numerators
    // over the determinant.
    assign is_nrm  = djob_reg <= DJ_LAST_NRM;
    assign didx    = is_nrm ? djob_reg[1:0] : 2'(djob_reg - DJ_FIRST_TAN);
    assign div_dvd = is_nrm ? DIVD_W'({cm_reg[didx][30:0], {FRAC_W{1'b0}}})
                            : {nm_reg[didx], {FRAC_W{1'b0}}};
    assign div_dvs = is_nrm ? DVS_W'(sr_reg[ROOT_W-1:0]) : detm_reg;

    always_comb
    begin
        e_big = 1'b0;
        for (int i = 0; i < 6; i++)
            e_big = e_big | (|am_reg[i][EDGE_W-1:NRM_PRE]);
        c_any = 1'b0;
        c_hi  = 1'b0;
        c_lo  = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            c_any = c_any | (|cm_reg[i]);
            c_hi  = c_hi | (|cm_reg[i][CM_W-1:31]);
            c_lo  = c_lo & ~(|cm_reg[i][CM_W-1:30]);
        end
    end

    assign sbit = L2_W'(1) << {sk_reg, 1'b0};
    assign stry = sr_reg + sbit;

    always_comb
    begin
        qr     = {1'b0, div_quo} + (QUO_W+1)'(div_rnd);
        nmag   = (qr > NRM_ONE) ? NRM_ONE : qr;
        nmag_s = cs_reg[didx] ? (~nmag[NRM_W-1:0] + 1'b1) : nmag[NRM_W-1:0];
        tneg   = ns_reg[didx] ^ dets_reg;
        tlim   = tneg ? NEG_LIM : POS_LIM;
        if (div_ovf || div_quo[QUO_W-1])
            tmag = tlim;
        else
            tmag = (qr > tlim) ? tlim : qr;
        tval   = tneg ? (~tmag + 1'b1) : tmag;
    end

    always_comb
    begin
        state_next    = state_reg;
        corner_next   = corner_reg;
        issued_next   = issued_reg;
        job_next      = job_reg;
        djob_next     = djob_reg;
        ndeg_next     = ndeg_reg;
        udeg_next     = udeg_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        p0_next       = p0_reg;
        p1_next       = p1_reg;
        t0_next       = t0_reg;
        t1_next       = t1_reg;
        em_next       = em_reg;
        am_next       = am_reg;
        es_next       = es_reg;
        dm_next       = dm_reg;
        ds_next       = ds_reg;
        tmp_next      = tmp_reg;
        cm_next       = cm_reg;
        cs_next       = cs_reg;
        nm_next       = nm_reg;
        ns_next       = ns_reg;
        detm_next     = detm_reg;
        dets_next     = dets_reg;
        l2_next       = l2_reg;
        sx_next       = sx_reg;
        sr_next       = sr_reg;
        sk_next       = sk_reg;
        n_next        = n_reg;
        tg_next       = tg_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_start     = 1'b0;
        div_start     = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (corner_reg)
                        2'd0:
                        begin
                            p0_next     = in_p;
                            t0_next     = in_t;
                            corner_next = 2'd1;
                        end
                        2'd1:
                        begin
                            p1_next     = in_p;
                            t1_next     = in_t;
                            corner_next = 2'd2;
                        end
                        default:
                        begin
                            // Third corner: latch edges and UV deltas as sign
                            // and magnitude, then start the sequence.
                            corner_next = 2'd0;
                            for (int i = 0; i < 6; i++)
                            begin
                                es_next[i] = e_new[i][EDGE_W-1];
                                em_next[i] = e_new[i][EDGE_W-1] ? (~e_new[i] + 1'b1) : e_new[i];
                                am_next[i] = em_next[i];
                            end
                            for (int i = 0; i < 4; i++)
                            begin
                                ds_next[i] = d_new[i][DUV_W-1];
                                dm_next[i] = d_new[i][DUV_W-1] ? (~d_new[i] + 1'b1) : d_new[i];
                            end
                            for (int i = 0; i < 3; i++)
                            begin
                                n_next[i]  = '0;
                                tg_next[i] = '0;
                            end
                            l2_next     = '0;
                            ndeg_next   = 1'b0;
                            udeg_next   = 1'b0;
                            job_next    = J_A1A5;
                            djob_next   = DJ_FIRST_NRM;
                            issued_next = 1'b0;
                            state_next  = ST_EPRE;
                        end
                    endcase
                end
            end

            ST_EPRE:
            begin
                if (e_big)
                begin
                    for (int i = 0; i < 6; i++)
                        am_next[i] = am_reg[i] >> 1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_MUL:
            begin
                if (!issued_reg)
                begin
                    mul_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (mul_done)
                begin
                    issued_next = 1'b0;
                    job_next    = job_reg + 1'b1;
                    unique case (job_reg) inside
                        J_A1A5, J_A2A3, J_A0A4, J_D0D3, J_D3E0, J_D3E1, J_D3E2:
                        begin
                            tmp_next = ps;
                        end
                        J_A2A4:
                        begin
                            cm_next[0] = dmag[CM_W-1:0]; cs_next[0] = dneg;
                        end
                        J_A0A5:
                        begin
                            cm_next[1] = dmag[CM_W-1:0]; cs_next[1] = dneg;
                        end
                        J_A1A3:
                        begin
                            cm_next[2] = dmag[CM_W-1:0]; cs_next[2] = dneg;
                        end
                        J_D2D1:
                        begin
                            detm_next = dmag[DET_W-1:0];
                            dets_next = dneg;
                            udeg_next = (dmag == '0);
                        end
                        J_D1E3:
                        begin
                            nm_next[0] = dmag[NM_W-1:0]; ns_next[0] = dneg;
                        end
                        J_D1E4:
                        begin
                            nm_next[1] = dmag[NM_W-1:0]; ns_next[1] = dneg;
                        end
                        J_D1E5:
                        begin
                            nm_next[2]  = dmag[NM_W-1:0];
                            ns_next[2]  = dneg;
                            state_next  = ST_CNORM;
                        end
                        J_SQ0, J_SQ1:
                        begin
                            l2_next = l2_reg + mul_prod[L2_W-1:0];
                        end
                        J_SQ2:
                        begin
                            sx_next    = l2_reg + mul_prod[L2_W-1:0];
                            sr_next    = '0;
                            sk_next    = SK_W'(SQ_STEPS - 1);
                            state_next = ST_SQRT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_CNORM:
            begin
                // Bring the largest cross component into [2^30, 2^31), or flag a zero normal.
                if (!c_any)
                begin
                    ndeg_next  = 1'b1;
                    djob_next  = DJ_FIRST_TAN;
                    state_next = udeg_reg ? ST_DONE : ST_DIV;
                end
                else if (c_hi)
                begin
                    for (int i = 0; i < 3; i++)
                        cm_next[i] = cm_reg[i] >> 1;
                end
                else if (c_lo)
                begin
                    for (int i = 0; i < 3; i++)
                        cm_next[i] = cm_reg[i] << 1;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end

            ST_SQRT:
            begin
                if (sx_reg >= stry)
                begin
                    sx_next = sx_reg - stry;
                    sr_next = (sr_reg >> 1) + sbit;
                end
                else
                begin
                    sr_next = sr_reg >> 1;
                end
                sk_next = sk_reg - 1'b1;
                if (sk_reg == '0)
                begin
                    djob_next  = DJ_FIRST_NRM;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                if (!issued_reg)
                begin
                    div_start   = 1'b1;
                    issued_next = 1'b1;
                end
                else if (div_done)
                begin
                    issued_next = 1'b0;
                    djob_next   = djob_reg + 1'b1;
                    if (is_nrm)
                        n_next[didx] = nmag_s;
                    else
                        tg_next[didx] = tval[TAN_W-1:0];
                    if ((djob_reg == DJ_LAST_NRM && udeg_reg) || djob_reg == DJ_LAST_TAN)
                        state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {tg_reg[2], tg_reg[1], tg_reg[0],
                                     n_reg[2], n_reg[1], n_reg[0]};
                    m_tuser_next  = {udeg_reg, ndeg_reg};
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            corner_reg   <= '0;
            issued_reg   <= 1'b0;
            job_reg      <= J_A1A5;
            djob_reg     <= DJ_FIRST_NRM;
            ndeg_reg     <= 1'b0;
            udeg_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            corner_reg   <= corner_next;
            issued_reg   <= issued_next;
            job_reg      <= job_next;
            djob_reg     <= djob_next;
            ndeg_reg     <= ndeg_next;
            udeg_reg     <= udeg_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_reg      <= p0_next;
        p1_reg      <= p1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        em_reg      <= em_next;
        am_reg      <= am_next;
        es_reg      <= es_next;
        dm_reg      <= dm_next;
        ds_reg      <= ds_next;
        tmp_reg     <= tmp_next;
        cm_reg      <= cm_next;
        cs_reg      <= cs_next;
        nm_reg      <= nm_next;
        ns_reg      <= ns_next;
        detm_reg    <= detm_next;
        dets_reg    <= dets_next;
        l2_reg      <= l2_next;
        sx_reg      <= sx_next;
        sr_reg      <= sr_next;
        sk_reg      <= sk_next;
        n_reg       <= n_next;
        tg_reg      <= tg_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    tnt_serial_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (op_a),
        .b     (op_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    tnt_serial_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quo      (div_quo),
        .ovf      (div_ovf),
        .round_up (div_rnd)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_done_after_third: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (corner_reg == 2'd0))
        else $error("result pending while a triangle is partly loaded");

    a_mul_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL && issued_reg))
        else $error("multiplier finished outside a product job");

    a_ndeg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata[3*NRM_W-1:0] == '0))
        else $error("degenerate normal with nonzero components");

    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[NRM_W-1:0]) <= 16384 &&
                      $signed(m_tdata[NRM_W-1:0]) >= -16384))
        else $error("normal x outside unit range");
`endif

endmodule
